// ===== sv/aabb_collider_table_sweep_macros.svh =====
// Assertion macros for the checker file.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef AABB_COLLIDER_TABLE_SWEEP_MACROS_SVH
`define AABB_COLLIDER_TABLE_SWEEP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ACS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Shared codes, widths, control structs and the kind-pair lookup for the
// collider table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acs_pkg;

   // Command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SWEEP  = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_REMOVED = 2'd2;
   localparam logic [1:0] ST_SWEEP   = 2'd3;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 4;
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int KIND_W  = 3;
   localparam int MASK_W  = 16;
   localparam int PAIR_W  = 25;

   // Internal edge width: holds an extended coordinate plus a size
   localparam int EDGE_W  = 18;

   localparam logic [KIND_W-1:0] KIND_MAX      = 3'd4;
   localparam logic [PAIR_W-1:0] PAIR_EN_RESET = 25'd2166660;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic do_add;
      logic do_remove;
      logic load_row;
   } acs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic row_end;
   } acs_stat_type;

   // Look up whether kind r may be notified about kind c
   function automatic logic pair_bit(logic [PAIR_W-1:0] m,
                                     logic [KIND_W-1:0] r,
                                     logic [KIND_W-1:0] c);
      logic [4:0] idx;
      logic       hit;
      idx = 5'({2'b00, r} * 5'd5 + {2'b00, c});
      if ((r > KIND_MAX) || (c > KIND_MAX)) begin
         hit = 1'b0;
      end else begin
         hit = m[idx];
      end
      return hit;
   endfunction

endpackage

// ===== sv/acs_ctrl.sv =====
// ----------------------------------------------------------------------------
// acs_ctrl
// Command sequencer: takes a request, steps the datapath through an add,
// a remove or a row-by-row sweep, and drives busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [acs_pkg::CMD_W-1:0]  req_cmd,
   input  acs_pkg::acs_stat_type      stat,
   output acs_pkg::acs_cmd_type       cmd,
   output logic                       busy
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_REMOVE,
      S_SWEEP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Decode next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_cmd)
                  acs_pkg::CMD_ADD:    state_in = S_ADD;
                  acs_pkg::CMD_REMOVE: state_in = S_REMOVE;
                  acs_pkg::CMD_SWEEP:  state_in = S_SWEEP;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_ADD:    state_in = S_IDLE;
         S_REMOVE: state_in = S_IDLE;
         S_SWEEP: begin
            if (stat.row_end) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   // Hold state and busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   // Drive datapath commands
   always_comb begin
      cmd.load_req  = (state_ff == S_IDLE) && start;
      cmd.do_add    = (state_ff == S_ADD);
      cmd.do_remove = (state_ff == S_REMOVE);
      cmd.load_row  = (state_ff == S_SWEEP);
   end

   assign busy = busy_ff;

endmodule

// ===== sv/acs_dpath.sv =====
// ----------------------------------------------------------------------------
// acs_dpath
// Collider table, request latch, sweep row register with one comparator
// lane per slot, enable register and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acs_dpath #(
   parameter int SLOTS      = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  acs_pkg::acs_cmd_type              cmd,
   output acs_pkg::acs_stat_type             stat,
   input  logic [acs_pkg::SLOT_W-1:0]        req_target_slot,
   input  logic signed [acs_pkg::COORD_W-1:0] req_left_x,
   input  logic signed [acs_pkg::COORD_W-1:0] req_top_y,
   input  logic [acs_pkg::SIZE_W-1:0]        req_width,
   input  logic [acs_pkg::SIZE_W-1:0]        req_height,
   input  logic [acs_pkg::KIND_W-1:0]        req_kind,
   input  logic                              req_wants_notify,
   input  logic                              csr_write_en,
   input  logic [acs_pkg::PAIR_W-1:0]        csr_write_data,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [acs_pkg::SLOT_W-1:0]        rsp_slot_index,
   output logic [acs_pkg::MASK_W-1:0]        rsp_hit_mask,
   output logic                              rsp_last
);

   localparam int SW = $clog2(SLOTS);
   localparam int EW = acs_pkg::EDGE_W;
   localparam int CB = (COORD_BITS > 16) ? 16 : COORD_BITS;

   // Extend a request coordinate from its low COORD_BITS bits, capped at 16
   function automatic logic signed [EW-1:0] ext_coord(logic [acs_pkg::COORD_W-1:0] v);
      logic [EW-1:0] vz;
      logic [EW-1:0] r;
      vz = {{(EW-acs_pkg::COORD_W){1'b0}}, v};
      for (int b = 0; b < EW; b++) begin
         r[b] = (b < CB) ? vz[b] : ((COORD_BITS > 16) ? 1'b0 : vz[CB-1]);
      end
      return $signed(r);
   endfunction

   // Request latch
   logic [acs_pkg::SLOT_W-1:0]  req_slot_ff;
   logic [acs_pkg::COORD_W-1:0] req_x_ff, req_y_ff;
   logic [acs_pkg::SIZE_W-1:0]  req_w_ff, req_h_ff;
   logic [acs_pkg::KIND_W-1:0]  req_kind_ff;
   logic                        req_notify_ff;

   // Table
   logic [SLOTS-1:0]             valid_ff, valid_in;
   logic signed [EW-1:0]         ent_x_ff [SLOTS];
   logic signed [EW-1:0]         ent_r_ff [SLOTS];
   logic signed [EW-1:0]         ent_y_ff [SLOTS];
   logic signed [EW-1:0]         ent_b_ff [SLOTS];
   logic [acs_pkg::KIND_W-1:0]   ent_kind_ff [SLOTS];
   logic [SLOTS-1:0]             ent_notify_ff;

   logic [acs_pkg::PAIR_W-1:0]   pair_en_ff;

   // Add path
   logic [SW-1:0]                free_idx;
   logic                         full;
   logic signed [EW-1:0]         new_x_in, new_r_in, new_y_in, new_b_in;

   // Remove path
   logic                         rm_in_range;
   logic [SW+acs_pkg::SLOT_W-1:0] rm_wide;
   logic [SW-1:0]                rm_idx;

   // Sweep row
   logic [SW-1:0]                row_cnt_ff, row_cnt_in;
   logic                         row_vld_ff;
   logic                         row_last_ff;
   logic [SW-1:0]                row_idx_ff;
   logic                         row_act_ff;
   logic [acs_pkg::KIND_W-1:0]   row_kind_ff;
   logic signed [EW-1:0]         row_x_ff, row_r_ff, row_y_ff, row_b_ff;
   logic [SLOTS-1:0]             mask_in;

   // Result registers
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [acs_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [acs_pkg::MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [SW+acs_pkg::SLOT_W-1:0] slot_wide;
   logic [SLOTS+acs_pkg::MASK_W-1:0] mask_wide;

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_slot_ff   <= req_target_slot;
         req_x_ff      <= req_left_x;
         req_y_ff      <= req_top_y;
         req_w_ff      <= req_width;
         req_h_ff      <= req_height;
         req_kind_ff   <= req_kind;
         req_notify_ff <= req_wants_notify;
      end
   end

   // Find the lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SW'(i);
         end
      end
      full = &valid_ff;
   end

   // Form the edges of a new entry
   always_comb begin
      new_x_in = ext_coord(req_x_ff);
      new_y_in = ext_coord(req_y_ff);
      new_r_in = new_x_in + $signed({{(EW-acs_pkg::SIZE_W){1'b0}}, req_w_ff});
      new_b_in = new_y_in + $signed({{(EW-acs_pkg::SIZE_W){1'b0}}, req_h_ff});
   end

   // Map the remove target onto a slot index
   always_comb begin
      rm_in_range = ({{(SW+1){1'b0}}, req_slot_ff} < (SW + acs_pkg::SLOT_W + 1)'(SLOTS));
      rm_wide     = {{SW{1'b0}}, req_slot_ff};
      rm_idx      = rm_wide[SW-1:0];
   end

   // Update valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.do_add && !full) begin
         valid_in[free_idx] = 1'b1;
      end
      if (cmd.do_remove && rm_in_range) begin
         valid_in[rm_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Write entry payload on add
   always_ff @(posedge clock) begin
      if (cmd.do_add && !full) begin
         ent_x_ff[free_idx]      <= new_x_in;
         ent_r_ff[free_idx]      <= new_r_in;
         ent_y_ff[free_idx]      <= new_y_in;
         ent_b_ff[free_idx]      <= new_b_in;
         ent_kind_ff[free_idx]   <= req_kind_ff;
         ent_notify_ff[free_idx] <= req_notify_ff;
      end
   end

   // Hold the kind-pair enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_en_ff <= acs_pkg::PAIR_EN_RESET;
      end else if (csr_write_en) begin
         pair_en_ff <= csr_write_data;
      end
   end

   // Advance the sweep row counter
   always_comb begin
      row_cnt_in = row_cnt_ff;
      if (cmd.load_req) begin
         row_cnt_in = '0;
      end else if (cmd.load_row) begin
         row_cnt_in = row_cnt_ff + SW'(1);
      end
      stat.row_end = (row_cnt_ff == SW'(SLOTS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         row_vld_ff <= 1'b0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         row_vld_ff <= cmd.load_row;
      end
   end

   // Load the current row into the compare register
   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         row_last_ff <= stat.row_end;
         row_idx_ff  <= row_cnt_ff;
         row_act_ff  <= valid_ff[row_cnt_ff] && ent_notify_ff[row_cnt_ff];
         row_kind_ff <= ent_kind_ff[row_cnt_ff];
         row_x_ff    <= ent_x_ff[row_cnt_ff];
         row_r_ff    <= ent_r_ff[row_cnt_ff];
         row_y_ff    <= ent_y_ff[row_cnt_ff];
         row_b_ff    <= ent_b_ff[row_cnt_ff];
      end
   end

   // Compare the row against every slot, one lane per slot
   for (genvar j = 0; j < SLOTS; j++) begin : g_lane
      assign mask_in[j] = row_act_ff && valid_ff[j] && (row_idx_ff != SW'(j))
                       && acs_pkg::pair_bit(pair_en_ff, row_kind_ff, ent_kind_ff[j])
                       && (row_x_ff < ent_r_ff[j]) && (row_r_ff > ent_x_ff[j])
                       && (row_y_ff < ent_b_ff[j]) && (row_b_ff > ent_y_ff[j]);
   end

   // Select the next result
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_status_in = acs_pkg::ST_ADDED;
      rsp_mask_in   = '0;
      rsp_last_in   = 1'b1;
      slot_wide     = '0;
      mask_wide     = {{acs_pkg::MASK_W{1'b0}}, mask_in};
      if (cmd.do_add) begin
         rsp_strobe_in = 1'b1;
         if (full) begin
            rsp_status_in = acs_pkg::ST_FULL;
         end else begin
            rsp_status_in = acs_pkg::ST_ADDED;
            slot_wide     = {{acs_pkg::SLOT_W{1'b0}}, free_idx};
         end
      end else if (cmd.do_remove) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = acs_pkg::ST_REMOVED;
         slot_wide     = {{SW{1'b0}}, req_slot_ff};
      end else if (row_vld_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = acs_pkg::ST_SWEEP;
         slot_wide     = {{acs_pkg::SLOT_W{1'b0}}, row_idx_ff};
         rsp_mask_in   = mask_wide[acs_pkg::MASK_W-1:0];
         rsp_last_in   = row_last_ff;
      end
      rsp_slot_in = slot_wide[acs_pkg::SLOT_W-1:0];
   end

   // Register the result and its strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_hit_mask   = rsp_mask_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== sv/aabb_collider_table_sweep.sv =====
// ----------------------------------------------------------------------------
// aabb_collider_table_sweep: rectangle collider table with all-pairs sweep
// Add and remove: the request is latched and the add or remove state updates
// the table and registers the result. Sweep: one row per cycle from the row
// counter. New requests are taken only in idle. Sync reset clears the table.
// Results cannot be stalled: each one is strobed for a single cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_collider_table_sweep #(
   parameter int SLOTS      = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [acs_pkg::CMD_W-1:0]          req_cmd,
   input  logic [acs_pkg::SLOT_W-1:0]         req_target_slot,
   input  logic signed [acs_pkg::COORD_W-1:0] req_left_x,
   input  logic signed [acs_pkg::COORD_W-1:0] req_top_y,
   input  logic [acs_pkg::SIZE_W-1:0]         req_width,
   input  logic [acs_pkg::SIZE_W-1:0]         req_height,
   input  logic [acs_pkg::KIND_W-1:0]         req_kind,
   input  logic                               req_wants_notify,
   input  logic                               csr_write_en,
   input  logic [acs_pkg::PAIR_W-1:0]         csr_write_data,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [acs_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic [acs_pkg::MASK_W-1:0]         rsp_hit_mask,
   output logic                               rsp_last
);

   acs_pkg::acs_cmd_type  cmd;
   acs_pkg::acs_stat_type stat;

   // Sequencer
   acs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   // Table and compare lanes
   acs_dpath #(
      .SLOTS      (SLOTS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_target_slot  (req_target_slot),
      .req_left_x       (req_left_x),
      .req_top_y        (req_top_y),
      .req_width        (req_width),
      .req_height       (req_height),
      .req_kind         (req_kind),
      .req_wants_notify (req_wants_notify),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_hit_mask     (rsp_hit_mask),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== sv/acs_checker.sv =====
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks on the collider table's results and busy behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aabb_collider_table_sweep_macros.svh"

module acs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [acs_pkg::CMD_W-1:0]          req_cmd,
   input logic                               rsp_strobe,
   input logic [1:0]                         rsp_status,
   input logic [acs_pkg::SLOT_W-1:0]         rsp_slot_index,
   input logic [acs_pkg::MASK_W-1:0]         rsp_hit_mask,
   input logic                               rsp_last
);

   // Single-result commands always close their transfer
   `ACS_ASSERT_SAME(a_single_last, rsp_strobe && (rsp_status != acs_pkg::ST_SWEEP), rsp_last, "add/remove result without last")

   // Only sweep rows carry a mask
   `ACS_ASSERT_SAME(a_mask_sweep_only, rsp_strobe && (rsp_status != acs_pkg::ST_SWEEP), rsp_hit_mask == '0, "mask set outside a sweep row")

   // A full table reports slot zero
   `ACS_ASSERT_SAME(a_full_slot, rsp_strobe && (rsp_status == acs_pkg::ST_FULL), rsp_slot_index == '0, "table full with nonzero slot")

   // A sweep transfer holds the block busy
   `ACS_ASSERT_NEXT(a_sweep_busy, start && !busy && (req_cmd == acs_pkg::CMD_SWEEP), busy, "sweep accepted without busy")

endmodule

bind aabb_collider_table_sweep acs_checker u_acs_checker (.*);
